/* rtl/core/lbf_pkg.sv */
// ----------------------------------------------------------------------------
// lbf_pkg
// Shared widths, pipeline depths and payload types of the Lorentz boost unit.
// ----------------------------------------------------------------------------
package lbf_pkg;

  // Every vector component is a signed Q15.16 word.
  localparam int unsigned DATA_W = 32;

  // Radicand and root of the integer square root.
  localparam int unsigned RAD_W      = 64;
  localparam int unsigned SQRT_STEPS = RAD_W / 2;

  // Rounding divider: dividend, divisor and quotient widths.
  localparam int unsigned DIVIDEND_W = 97;
  localparam int unsigned DIVISOR_W  = 64;
  localparam int unsigned QUOT_W     = 33;

  // Width of the dot product, of the numerators and of the limb split.
  localparam int unsigned DOT_W   = 66;
  localparam int unsigned NUMER_W = 67;
  localparam int unsigned LIMB_W  = 23;
  localparam int unsigned N_LIMBS = 3;

  // Register stages ahead of the root, after it, and in the divider.
  localparam int unsigned PRE_STAGES  = 4;
  localparam int unsigned POST_STAGES = 7;
  localparam int unsigned DIV_STAGES  = QUOT_W + 1;
  localparam int unsigned LATENCY     = PRE_STAGES + SQRT_STEPS + POST_STAGES
                                        + DIV_STAGES + 1;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Raw input item as it travels down the pipeline.
  typedef struct packed {
    logic [DATA_W-1:0]       e;
    logic [2:0][DATA_W-1:0]  p;
    logic [DATA_W-1:0]       ef;
    logic [2:0][DATA_W-1:0]  f;
  } lbf_vec_t;

  // Item context carried alongside the square root.
  typedef struct packed {
    lbf_vec_t           vec;
    logic [DOT_W-1:0]   dot;
    logic [NUMER_W-1:0] n;
    logic               pass;
    logic               inv;
  } lbf_ctx_t;

  // What the output stage needs besides the quotients.
  typedef struct packed {
    logic                    pass;
    logic                    inv;
    logic                    e_neg;
    logic [DATA_W-1:0]       e;
    logic [2:0][DATA_W-1:0]  p;
  } lbf_tail_t;

endpackage

/* rtl/core/lbf_rdiv.sv */
// ----------------------------------------------------------------------------
// lbf_rdiv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module lbf_rdiv #(
  parameter int unsigned NUM_W  = lbf_pkg::DIVIDEND_W,
  parameter int unsigned DEN_W  = lbf_pkg::DIVISOR_W,
  parameter int unsigned QUO_W  = lbf_pkg::QUOT_W,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  dividend_i,
  input  logic [DEN_W-1:0]  divisor_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quot_o,
  output logic              ovf_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned WIDE_W = DEN_W + QUO_W;

  logic [WIDE_W-1:0] num_ext;
  logic [WIDE_W-1:0] den_ext;

  logic              valid_q [QUO_W+1];
  logic [DEN_W-1:0]  rem_q   [QUO_W+1];
  logic [QUO_W-1:0]  lo_q    [QUO_W+1];
  logic [QUO_W-1:0]  quo_q   [QUO_W+1];
  logic [DEN_W-1:0]  den_q   [QUO_W+1];
  logic              ovf_q   [QUO_W+1];
  logic [SIDE_W-1:0] side_q  [QUO_W+1];

  assign num_ext = WIDE_W'(dividend_i);
  assign den_ext = {divisor_i, {QUO_W{1'b0}}};

  // Entry stage: a quotient that needs more than QUO_W bits is flagged here,
  // otherwise the upper part of the dividend is already below the divisor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= num_ext[WIDE_W-1:QUO_W];
    lo_q[0]   <= num_ext[QUO_W-1:0];
    quo_q[0]  <= '0;
    den_q[0]  <= divisor_i;
    ovf_q[0]  <= (num_ext >= den_ext);
    side_q[0] <= side_i;
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = {rem_q[k-1], lo_q[k-1][QUO_W-1]};
    assign diff  = trial - {1'b0, den_q[k-1]};
    assign ge    = (trial >= {1'b0, den_q[k-1]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      lo_q[k]   <= {lo_q[k-1][QUO_W-2:0], 1'b0};
      quo_q[k]  <= {quo_q[k-1][QUO_W-2:0], ge};
      den_q[k]  <= den_q[k-1];
      ovf_q[k]  <= ovf_q[k-1];
      side_q[k] <= side_q[k-1];
    end
  end

  assign valid_o = valid_q[QUO_W];
  assign quot_o  = quo_q[QUO_W];
  assign ovf_o   = ovf_q[QUO_W];
  assign side_o  = side_q[QUO_W];

endmodule

/* rtl/core/lorentz_boost_to_frame_unit.sv */
// ----------------------------------------------------------------------------
// lorentz_boost_to_frame_unit
// Boosts a four-vector into the rest frame of a reference four-vector.
// ----------------------------------------------------------------------------
// The unit takes one item in every clock cycle and is never busy; busy is
// held low. Each item leaves the pipeline after all of its stages, marked by
// a one-cycle done_o strobe, in the order the items came in. The depth of the
// pipeline is set by the 32-stage square root of the frame mass and by the
// 34-stage rounding dividers, one result bit per stage, plus twelve stages of
// products, sums and the output register. All values are signed Q15.16. The
// invariant mass m of the frame is the integer square root of Ef^2 - |pf|^2;
// the energy is divided by m and the momenta by m(|Ef| + m), both rounded to
// nearest with ties away from zero, and every component saturates to 32 bits.
// A frame with zero momentum or zero energy returns the input unchanged with
// passed_through_o set; a frame with |pf| >= |Ef| returns zeros with
// invalid_beta_o set. The receiver cannot hold results off.
// ----------------------------------------------------------------------------
module lorentz_boost_to_frame_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] energy_in_i,
  input  logic [31:0] mom_x_in_i,
  input  logic [31:0] mom_y_in_i,
  input  logic [31:0] mom_z_in_i,
  input  logic [31:0] frame_energy_i,
  input  logic [31:0] frame_mom_x_i,
  input  logic [31:0] frame_mom_y_i,
  input  logic [31:0] frame_mom_z_i,
  output logic        done_o,
  output logic [31:0] energy_out_o,
  output logic [31:0] mom_x_out_o,
  output logic [31:0] mom_y_out_o,
  output logic [31:0] mom_z_out_o,
  output logic        passed_through_o,
  output logic        invalid_beta_o,
  output logic        saturated_o
);

  localparam int unsigned DW     = lbf_pkg::DATA_W;
  localparam int unsigned RW     = lbf_pkg::RAD_W;
  localparam int unsigned STEPS  = lbf_pkg::SQRT_STEPS;
  localparam int unsigned NW     = lbf_pkg::NUMER_W;
  localparam int unsigned DTW    = lbf_pkg::DOT_W;
  localparam int unsigned LW     = lbf_pkg::LIMB_W;
  localparam int unsigned NL     = lbf_pkg::N_LIMBS;
  localparam int unsigned PAD_W  = LW * NL;
  localparam int unsigned PP_W   = LW + DW;
  localparam int unsigned DVN_W  = lbf_pkg::DIVIDEND_W;
  localparam int unsigned DVD_W  = lbf_pkg::DIVISOR_W;
  localparam int unsigned QW     = lbf_pkg::QUOT_W;
  localparam int unsigned SUM_W  = QW + 2;
  localparam int unsigned TAIL_W = $bits(lbf_pkg::lbf_tail_t);

  logic acc;

  // Nothing in the pipeline ever stalls, so an item is taken every cycle.
  assign busy = 1'b0;
  assign acc  = start & ~busy;

  // --------------------------------------------------------------------------
  // Stage 1: input register.
  // --------------------------------------------------------------------------
  logic              s1_v_q;
  lbf_pkg::lbf_vec_t s1_vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_vec_q.e    <= energy_in_i;
      s1_vec_q.p[0] <= mom_x_in_i;
      s1_vec_q.p[1] <= mom_y_in_i;
      s1_vec_q.p[2] <= mom_z_in_i;
      s1_vec_q.ef   <= frame_energy_i;
      s1_vec_q.f[0] <= frame_mom_x_i;
      s1_vec_q.f[1] <= frame_mom_y_i;
      s1_vec_q.f[2] <= frame_mom_z_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: all 32x32 products that the frame test, the dot product and the energy numerator need.
  // --------------------------------------------------------------------------
  logic signed [2*DW-1:0] s2_fsq_d [3];
  logic signed [2*DW-1:0] s2_fp_d  [3];
  logic signed [2*DW-1:0] s2_ef2_d;
  logic signed [2*DW-1:0] s2_efe_d;
  logic                   s2_pass_d;

  logic                   s2_v_q;
  logic signed [2*DW-1:0] s2_fsq_q [3];
  logic signed [2*DW-1:0] s2_fp_q  [3];
  logic signed [2*DW-1:0] s2_ef2_q;
  logic signed [2*DW-1:0] s2_efe_q;
  logic                   s2_pass_q;
  lbf_pkg::lbf_vec_t      s2_vec_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_fsq_d[i] = $signed(s1_vec_q.f[i]) * $signed(s1_vec_q.f[i]);
      s2_fp_d[i]  = $signed(s1_vec_q.f[i]) * $signed(s1_vec_q.p[i]);
    end
    s2_ef2_d  = $signed(s1_vec_q.ef) * $signed(s1_vec_q.ef);
    s2_efe_d  = $signed(s1_vec_q.ef) * $signed(s1_vec_q.e);
    // A frame at rest or with zero energy leaves the item as it is.
    s2_pass_d = ((s1_vec_q.f[0] == '0) && (s1_vec_q.f[1] == '0) && (s1_vec_q.f[2] == '0))
                || (s1_vec_q.ef == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_fsq_q  <= s2_fsq_d;
    s2_fp_q   <= s2_fp_d;
    s2_ef2_q  <= s2_ef2_d;
    s2_efe_q  <= s2_efe_d;
    s2_pass_q <= s2_pass_d;
    s2_vec_q  <= s1_vec_q;
  end

  // --------------------------------------------------------------------------
  // Stage 3: |pf|^2 and the dot product pf.p.
  // --------------------------------------------------------------------------
  logic [RW-1:0]          s3_pf2_d;
  logic signed [DTW-1:0]  s3_dot_d;

  logic                   s3_v_q;
  logic [RW-1:0]          s3_pf2_q;
  logic signed [DTW-1:0]  s3_dot_q;
  logic [RW-1:0]          s3_ef2_q;
  logic signed [2*DW-1:0] s3_efe_q;
  logic                   s3_pass_q;
  lbf_pkg::lbf_vec_t      s3_vec_q;

  // The squares are non-negative and their sum stays below 2^64.
  assign s3_pf2_d = $unsigned(s2_fsq_q[0]) + $unsigned(s2_fsq_q[1])
                    + $unsigned(s2_fsq_q[2]);
  assign s3_dot_d = s2_fp_q[0] + s2_fp_q[1] + s2_fp_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_pf2_q  <= s3_pf2_d;
    s3_dot_q  <= s3_dot_d;
    s3_ef2_q  <= $unsigned(s2_ef2_q);
    s3_efe_q  <= s2_efe_q;
    s3_pass_q <= s2_pass_q;
    s3_vec_q  <= s2_vec_q;
  end

  // --------------------------------------------------------------------------
  // Stage 4: superluminal test, radicand Ef^2 - |pf|^2 and the energy
  // numerator sgn(Ef)(Ef E - pf.p).
  // --------------------------------------------------------------------------
  logic                 s4_inv_d;
  logic [RW-1:0]        s4_rad_d;
  logic signed [NW-1:0] s4_n_d;

  logic                 s4_v_q;
  logic [RW-1:0]        s4_rad_q;
  lbf_pkg::lbf_ctx_t    s4_ctx_q;

  assign s4_inv_d = (s3_pf2_q >= s3_ef2_q);
  assign s4_rad_d = s4_inv_d ? '0 : (s3_ef2_q - s3_pf2_q);
  assign s4_n_d   = s3_vec_q.ef[DW-1] ? (s3_dot_q - s3_efe_q) : (s3_efe_q - s3_dot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_rad_q      <= s4_rad_d;
    s4_ctx_q.vec  <= s3_vec_q;
    s4_ctx_q.dot  <= s3_dot_q;
    s4_ctx_q.n    <= s4_n_d;
    s4_ctx_q.pass <= s3_pass_q;
    s4_ctx_q.inv  <= s4_inv_d;
  end

  // --------------------------------------------------------------------------
  // Square root: one digit-by-digit step per stage, highest bit first.
  // --------------------------------------------------------------------------
  logic              sq_v_q    [STEPS];
  logic [RW-1:0]     sq_rad_q  [STEPS];
  logic [RW-1:0]     sq_root_q [STEPS];
  lbf_pkg::lbf_ctx_t sq_ctx_q  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_sqrt
    localparam logic [RW-1:0] BIT = {{(RW-1){1'b0}}, 1'b1} << (RW - 2 - 2 * k);

    logic              v_in;
    logic [RW-1:0]     rad_in;
    logic [RW-1:0]     root_in;
    lbf_pkg::lbf_ctx_t ctx_in;
    logic [RW-1:0]     trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in    = s4_v_q;
      assign rad_in  = s4_rad_q;
      assign root_in = '0;
      assign ctx_in  = s4_ctx_q;
    end else begin : g_next
      assign v_in    = sq_v_q[k-1];
      assign rad_in  = sq_rad_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign ctx_in  = sq_ctx_q[k-1];
    end

    assign trial = root_in + BIT;
    assign ge    = (rad_in >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k] <= 1'b0;
      end else begin
        sq_v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      sq_rad_q[k]  <= ge ? (rad_in - trial) : rad_in;
      sq_root_q[k] <= ge ? ((root_in >> 1) + BIT) : (root_in >> 1);
      sq_ctx_q[k]  <= ctx_in;
    end
  end

  // The mass is at most 2^31, so the low word holds it completely.
  logic [DW-1:0] sq_mass;
  assign sq_mass = sq_root_q[STEPS-1][DW-1:0];

  // --------------------------------------------------------------------------
  // Stage A: a = |Ef| + m and |E|.
  // --------------------------------------------------------------------------
  logic [DW-1:0]     sa_efabs;
  logic [DW-1:0]     sa_eabs_d;

  logic              sa_v_q;
  logic [DW-1:0]     sa_m_q;
  logic [DW:0]       sa_a_q;
  logic [DW-1:0]     sa_eabs_q;
  lbf_pkg::lbf_ctx_t sa_ctx_q;

  assign sa_efabs  = sq_ctx_q[STEPS-1].vec.ef[DW-1] ? (~sq_ctx_q[STEPS-1].vec.ef + 1'b1)
                                                     : sq_ctx_q[STEPS-1].vec.ef;
  assign sa_eabs_d = sq_ctx_q[STEPS-1].vec.e[DW-1] ? (~sq_ctx_q[STEPS-1].vec.e + 1'b1)
                                                    : sq_ctx_q[STEPS-1].vec.e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_v_q <= 1'b0;
    end else begin
      sa_v_q <= sq_v_q[STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sa_m_q    <= sq_mass;
    sa_a_q    <= {1'b0, sa_efabs} + {1'b0, sq_mass};
    sa_eabs_q <= sa_eabs_d;
    sa_ctx_q  <= sq_ctx_q[STEPS-1];
  end

  // --------------------------------------------------------------------------
  // Stage B: momentum divisor m*a and the energy term |E|*a.
  // --------------------------------------------------------------------------
  logic [2*DW:0]     sb_den_d;
  logic [2*DW:0]     sb_term_d;

  logic              sb_v_q;
  logic [DVD_W-1:0]  sb_den_q;
  logic [2*DW:0]     sb_term_q;
  logic              sb_tneg_q;
  logic [DW-1:0]     sb_m_q;
  lbf_pkg::lbf_ctx_t sb_ctx_q;

  assign sb_den_d  = {{DW{1'b0}}, sa_m_q} * sa_a_q;
  assign sb_term_d = {{DW{1'b0}}, sa_eabs_q} * sa_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_v_q <= 1'b0;
    end else begin
      sb_v_q <= sa_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // m*(|Ef|+m) never reaches 2^64, so the top bit is always clear.
    sb_den_q  <= sb_den_d[DVD_W-1:0];
    sb_term_q <= sb_term_d;
    sb_tneg_q <= sa_ctx_q.vec.e[DW-1] ^ sa_ctx_q.vec.ef[DW-1];
    sb_m_q    <= sa_m_q;
    sb_ctx_q  <= sa_ctx_q;
  end

  // --------------------------------------------------------------------------
  // Stage C: momentum numerator q = pf.p - sgn(Ef) E (|Ef|+m).
  // --------------------------------------------------------------------------
  logic signed [NW-1:0] sc_term_s;
  logic signed [NW-1:0] sc_dot_s;

  logic                 sc_v_q;
  logic signed [NW-1:0] sc_q_q;
  logic [DVD_W-1:0]     sc_den_q;
  logic [DW-1:0]        sc_m_q;
  lbf_pkg::lbf_ctx_t    sc_ctx_q;

  assign sc_term_s = $signed(NW'(sb_term_q));
  assign sc_dot_s  = $signed(NW'($signed(sb_ctx_q.dot)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_v_q <= 1'b0;
    end else begin
      sc_v_q <= sb_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sc_q_q   <= sb_tneg_q ? (sc_dot_s + sc_term_s) : (sc_dot_s - sc_term_s);
    sc_den_q <= sb_den_q;
    sc_m_q   <= sb_m_q;
    sc_ctx_q <= sb_ctx_q;
  end

  // --------------------------------------------------------------------------
  // Stage D: magnitudes and signs of both numerators and of the frame momenta.
  // --------------------------------------------------------------------------
  logic [DW-1:0]     sd_fabs_d [3];

  logic              sd_v_q;
  logic [NW-1:0]     sd_qmag_q;
  logic [NW-1:0]     sd_nmag_q;
  logic              sd_nneg_q;
  logic [DW-1:0]     sd_fabs_q [3];
  logic [2:0]        sd_sgn_q;
  logic [DVD_W-1:0]  sd_den_q;
  logic [DW-1:0]     sd_m_q;
  lbf_pkg::lbf_ctx_t sd_ctx_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sd_fabs_d[i] = sc_ctx_q.vec.f[i][DW-1] ? (~sc_ctx_q.vec.f[i] + 1'b1)
                                             : sc_ctx_q.vec.f[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sd_v_q <= 1'b0;
    end else begin
      sd_v_q <= sc_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sd_qmag_q <= sc_q_q[NW-1] ? (~sc_q_q + 1'b1) : sc_q_q;
    sd_nmag_q <= sc_ctx_q.n[NW-1] ? (~sc_ctx_q.n + 1'b1) : sc_ctx_q.n;
    sd_nneg_q <= sc_ctx_q.n[NW-1];
    sd_fabs_q <= sd_fabs_d;
    for (int i = 0; i < 3; i++) begin
      sd_sgn_q[i] <= sc_q_q[NW-1] ^ sc_ctx_q.vec.f[i][DW-1];
    end
    sd_den_q  <= sc_den_q;
    sd_m_q    <= sc_m_q;
    sd_ctx_q  <= sc_ctx_q;
  end

  // --------------------------------------------------------------------------
  // Stage E: |q| * |f_i| as three limb products per axis.
  // --------------------------------------------------------------------------
  logic [PAD_W-1:0]  se_qpad;

  logic              se_v_q;
  logic [PP_W-1:0]   se_pp_q [3][NL];
  logic [NW-1:0]     se_nmag_q;
  logic              se_nneg_q;
  logic [2:0]        se_sgn_q;
  logic [DVD_W-1:0]  se_den_q;
  logic [DW-1:0]     se_m_q;
  lbf_pkg::lbf_ctx_t se_ctx_q;

  assign se_qpad = PAD_W'(sd_qmag_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      se_v_q <= 1'b0;
    end else begin
      se_v_q <= sd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < NL; j++) begin
        se_pp_q[i][j] <= PP_W'(se_qpad[j*LW +: LW]) * PP_W'(sd_fabs_q[i]);
      end
    end
    se_nmag_q <= sd_nmag_q;
    se_nneg_q <= sd_nneg_q;
    se_sgn_q  <= sd_sgn_q;
    se_den_q  <= sd_den_q;
    se_m_q    <= sd_m_q;
    se_ctx_q  <= sd_ctx_q;
  end

  // --------------------------------------------------------------------------
  // Stage F: the limb products summed into the full numerators.
  // --------------------------------------------------------------------------
  logic [DVN_W-1:0]  sf_num_d [3];

  logic              sf_v_q;
  logic [DVN_W-1:0]  sf_num_q [3];
  logic [NW-1:0]     sf_nmag_q;
  logic              sf_nneg_q;
  logic [2:0]        sf_sgn_q;
  logic [DVD_W-1:0]  sf_den_q;
  logic [DW-1:0]     sf_m_q;
  lbf_pkg::lbf_ctx_t sf_ctx_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sf_num_d[i] = '0;
      for (int j = 0; j < NL; j++) begin
        sf_num_d[i] = sf_num_d[i] + (DVN_W'(se_pp_q[i][j]) << (j * LW));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sf_v_q <= 1'b0;
    end else begin
      sf_v_q <= se_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sf_num_q  <= sf_num_d;
    sf_nmag_q <= se_nmag_q;
    sf_nneg_q <= se_nneg_q;
    sf_sgn_q  <= se_sgn_q;
    sf_den_q  <= se_den_q;
    sf_m_q    <= se_m_q;
    sf_ctx_q  <= se_ctx_q;
  end

  // --------------------------------------------------------------------------
  // Stage G: half the divisor added for round-half-away, divider operands.
  // Lane 0 divides the energy by m, lanes 1 to 3 the momenta by m(|Ef|+m).
  // --------------------------------------------------------------------------
  logic              sg_v_q;
  logic [DVN_W-1:0]  sg_num_q [4];
  logic [DVD_W-1:0]  sg_den_q [4];
  logic [2:0]        sg_sgn_q;
  lbf_pkg::lbf_tail_t sg_tail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sg_v_q <= 1'b0;
    end else begin
      sg_v_q <= sf_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sg_num_q[0] <= DVN_W'(sf_nmag_q) + DVN_W'(sf_m_q >> 1);
    sg_den_q[0] <= DVD_W'(sf_m_q);
    for (int i = 0; i < 3; i++) begin
      sg_num_q[i+1] <= sf_num_q[i] + DVN_W'(sf_den_q >> 1);
      sg_den_q[i+1] <= sf_den_q;
    end
    sg_sgn_q        <= sf_sgn_q;
    sg_tail_q.pass  <= sf_ctx_q.pass;
    sg_tail_q.inv   <= sf_ctx_q.inv;
    sg_tail_q.e_neg <= sf_nneg_q;
    sg_tail_q.e     <= sf_ctx_q.vec.e;
    sg_tail_q.p     <= sf_ctx_q.vec.p;
  end

  // --------------------------------------------------------------------------
  // Dividers.
  // --------------------------------------------------------------------------
  logic               dv_valid [4];
  logic [QW-1:0]      dv_quot  [4];
  logic               dv_ovf   [4];
  logic [3:0]         dv_sgn;
  logic [TAIL_W-1:0]  dv_tail_raw;
  lbf_pkg::lbf_tail_t dv_tail;

  lbf_rdiv #(
    .NUM_W  (DVN_W),
    .DEN_W  (DVD_W),
    .QUO_W  (QW),
    .SIDE_W (TAIL_W)
  ) u_div_e (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (sg_v_q),
    .dividend_i (sg_num_q[0]),
    .divisor_i  (sg_den_q[0]),
    .side_i     (sg_tail_q),
    .valid_o    (dv_valid[0]),
    .quot_o     (dv_quot[0]),
    .ovf_o      (dv_ovf[0]),
    .side_o     (dv_tail_raw)
  );

  assign dv_tail   = dv_tail_raw;
  assign dv_sgn[0] = dv_tail.e_neg;

  for (genvar l = 1; l < 4; l++) begin : g_div_p
    lbf_rdiv #(
      .NUM_W  (DVN_W),
      .DEN_W  (DVD_W),
      .QUO_W  (QW),
      .SIDE_W (1)
    ) u_div_p (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .valid_i    (sg_v_q),
      .dividend_i (sg_num_q[l]),
      .divisor_i  (sg_den_q[l]),
      .side_i     (sg_sgn_q[l-1]),
      .valid_o    (dv_valid[l]),
      .quot_o     (dv_quot[l]),
      .ovf_o      (dv_ovf[l]),
      .side_o     (dv_sgn[l])
    );
  end

  // --------------------------------------------------------------------------
  // Output stage: sign, momentum offset, saturation and the special cases.
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] fin_mag;
  logic signed [SUM_W-1:0] fin_val;
  logic signed [SUM_W-1:0] fin_add;
  logic [DW-1:0]           fin_res  [4];
  logic [3:0]              fin_clip;
  logic [DW-1:0]           out_d    [4];
  logic                    pass_d;
  logic                    inv_d;
  logic                    sat_d;
  logic                    dv_all_valid;

  assign dv_all_valid = dv_valid[0] & dv_valid[1] & dv_valid[2] & dv_valid[3];

  always_comb begin
    fin_mag = '0;
    fin_val = '0;
    fin_add = '0;
    for (int l = 0; l < 4; l++) begin
      fin_mag = $signed(SUM_W'(dv_quot[l]));
      if (l == 0) begin
        fin_add = '0;
      end else begin
        fin_add = SUM_W'($signed(dv_tail.p[l-1]));
      end
      fin_val = (dv_sgn[l] ? -fin_mag : fin_mag) + fin_add;
      if (dv_ovf[l]) begin
        fin_res[l]  = dv_sgn[l] ? lbf_pkg::SAT_MIN : lbf_pkg::SAT_MAX;
        fin_clip[l] = 1'b1;
      end else if ((fin_val[SUM_W-1:DW-1] != '0) && (fin_val[SUM_W-1:DW-1] != '1)) begin
        fin_res[l]  = fin_val[SUM_W-1] ? lbf_pkg::SAT_MIN : lbf_pkg::SAT_MAX;
        fin_clip[l] = 1'b1;
      end else begin
        fin_res[l]  = fin_val[DW-1:0];
        fin_clip[l] = 1'b0;
      end
    end

    if (dv_tail.pass) begin
      out_d[0] = dv_tail.e;
      for (int l = 1; l < 4; l++) begin
        out_d[l] = dv_tail.p[l-1];
      end
      pass_d = 1'b1;
      inv_d  = 1'b0;
      sat_d  = 1'b0;
    end else if (dv_tail.inv) begin
      for (int l = 0; l < 4; l++) begin
        out_d[l] = '0;
      end
      pass_d = 1'b0;
      inv_d  = 1'b1;
      sat_d  = 1'b0;
    end else begin
      out_d  = fin_res;
      pass_d = 1'b0;
      inv_d  = 1'b0;
      sat_d  = |fin_clip;
    end
  end

  logic          done_q;
  logic [DW-1:0] out_q [4];
  logic          pass_q;
  logic          inv_q;
  logic          sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_all_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pass_q <= pass_d;
    inv_q  <= inv_d;
    sat_q  <= sat_d;
  end

  assign done_o           = done_q;
  assign energy_out_o     = out_q[0];
  assign mom_x_out_o      = out_q[1];
  assign mom_y_out_o      = out_q[2];
  assign mom_z_out_o      = out_q[3];
  assign passed_through_o = pass_q;
  assign invalid_beta_o   = inv_q;
  assign saturated_o      = sat_q;

endmodule

/* rtl/core/lbf_checker.sv */
// ----------------------------------------------------------------------------
// lbf_checker
// Port-level checks of the Lorentz boost unit, bound to its top level.
// ----------------------------------------------------------------------------
module lbf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [31:0] energy_in_i,
  input logic [31:0] mom_x_in_i,
  input logic [31:0] energy_out_o,
  input logic [31:0] mom_x_out_o,
  input logic [31:0] mom_y_out_o,
  input logic [31:0] mom_z_out_o,
  input logic        passed_through_o,
  input logic        invalid_beta_o,
  input logic        saturated_o
);

  // Every item taken comes out after the fixed pipeline depth.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(lbf_pkg::LATENCY) done_o)
    else $error("item did not complete after the pipeline depth");

  // A result never appears without an item taken that many cycles before.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, lbf_pkg::LATENCY))
    else $error("result without a matching item");

  // A rejected frame yields a zero vector with no other flag.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && invalid_beta_o) |-> (energy_out_o == '0 && mom_x_out_o == '0
      && mom_y_out_o == '0 && mom_z_out_o == '0 && !saturated_o && !passed_through_o))
    else $error("invalid frame result is not clean zero");

  // A frame at rest or with zero energy echoes the energy and x momentum of the item that entered.
  a_pass_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && passed_through_o) |-> (energy_out_o == $past(energy_in_i, lbf_pkg::LATENCY)
      && mom_x_out_o == $past(mom_x_in_i, lbf_pkg::LATENCY) && !saturated_o))
    else $error("pass-through result differs from its item");

endmodule

bind lorentz_boost_to_frame_unit lbf_checker u_lbf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .done_o           (done_o),
  .energy_in_i      (energy_in_i),
  .mom_x_in_i       (mom_x_in_i),
  .energy_out_o     (energy_out_o),
  .mom_x_out_o      (mom_x_out_o),
  .mom_y_out_o      (mom_y_out_o),
  .mom_z_out_o      (mom_z_out_o),
  .passed_through_o (passed_through_o),
  .invalid_beta_o   (invalid_beta_o),
  .saturated_o      (saturated_o)
);

/* dv/lorentz_boost_to_frame_unit_test.sv */
// ----------------------------------------------------------------------------
// lorentz_boost_to_frame_unit_test
// Self-checking testbench of the Lorentz boost unit. A directed table covers
// pass-through, superluminal and extreme frames; random items follow. Every
// result is compared with its table entry or an independent wide-integer model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lorentz_boost_to_frame_unit_test;

  localparam logic [31:0] SAT_MAX = lbf_pkg::SAT_MAX;
  localparam logic [31:0] SAT_MIN = lbf_pkg::SAT_MIN;

  typedef struct packed {
    logic [31:0] e, px, py, pz, ef, fx, fy, fz;
  } boost_item_t;

  typedef struct packed {
    logic [31:0] e, px, py, pz;
    logic        pass, inv, sat;
  } boosted_t;

  typedef struct {
    boost_item_t item;
    logic        known;
    boosted_t    res;
  } table_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  boost_item_t drv = '0;
  logic        done_o;
  logic [31:0] energy_out_o, mom_x_out_o, mom_y_out_o, mom_z_out_o;
  logic        passed_through_o, invalid_beta_o, saturated_o;

  boosted_t    boosted_q[$];
  int          errors = 0;

  lorentz_boost_to_frame_unit dut (
    .clk_i, .rst_ni, .start, .busy,
    .energy_in_i(drv.e), .mom_x_in_i(drv.px), .mom_y_in_i(drv.py),
    .mom_z_in_i(drv.pz), .frame_energy_i(drv.ef), .frame_mom_x_i(drv.fx),
    .frame_mom_y_i(drv.fy), .frame_mom_z_i(drv.fz),
    .done_o, .energy_out_o, .mom_x_out_o, .mom_y_out_o, .mom_z_out_o,
    .passed_through_o, .invalid_beta_o, .saturated_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Floor integer square root of a 64-bit radicand, bit by bit.
  function automatic logic [63:0] frame_mass(logic [63:0] rad);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= rad) root = trial;
    end
    return root;
  endfunction

  // Signed division rounded to nearest with ties away from zero.
  function automatic logic signed [199:0] div_round(logic signed [199:0] num,
                                                    logic signed [199:0] den);
    logic signed [199:0] mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic logic [31:0] clamp32(logic signed [199:0] v, ref logic sat);
    if (v > 200'sd2147483647) begin
      sat = 1'b1;
      return SAT_MAX;
    end
    if (v < -200'sd2147483648) begin
      sat = 1'b1;
      return SAT_MIN;
    end
    return v[31:0];
  endfunction

  // Predicts the boosted four-vector of one item.
  function automatic boosted_t boost_into_frame(boost_item_t it);
    boosted_t r;
    logic signed [199:0] e, ef, fx, fy, fz, px, py, pz, pf2, ef2, m, a, dot;
    logic signed [199:0] n, q, den;
    logic sat;
    r = '0;
    sat = 1'b0;
    e = $signed(it.e); ef = $signed(it.ef);
    px = $signed(it.px); py = $signed(it.py); pz = $signed(it.pz);
    fx = $signed(it.fx); fy = $signed(it.fy); fz = $signed(it.fz);
    if ((fx == 0 && fy == 0 && fz == 0) || ef == 0) begin
      r.e = it.e; r.px = it.px; r.py = it.py; r.pz = it.pz;
      r.pass = 1'b1;
      return r;
    end
    pf2 = fx * fx + fy * fy + fz * fz;
    ef2 = ef * ef;
    if (pf2 >= ef2) begin
      r.inv = 1'b1;
      return r;
    end
    m = frame_mass(64'(ef2 - pf2));
    a = ((ef < 0) ? -ef : ef) + m;
    den = m * a;
    dot = fx * px + fy * py + fz * pz;
    n = ef * e - dot;
    if (ef < 0) n = -n;
    q = dot - ((ef < 0) ? -e : e) * a;
    r.e  = clamp32(div_round(n, m), sat);
    r.px = clamp32(div_round(fx * q, den) + px, sat);
    r.py = clamp32(div_round(fy * q, den) + py, sat);
    r.pz = clamp32(div_round(fz * q, den) + pz, sat);
    r.sat = sat;
    return r;
  endfunction

  // Results are sampled at the rising edge and matched in order.
  always @(posedge clk_i) begin
    boosted_t got, want;
    if (rst_ni && done_o) begin
      got = {energy_out_o, mom_x_out_o, mom_y_out_o, mom_z_out_o,
             passed_through_o, invalid_beta_o, saturated_o};
      if (boosted_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = boosted_q.pop_front();
        if (got.e !== want.e)
          $display("%0t: energy expected %h actual %h", $time, want.e, got.e);
        if (got.px !== want.px)
          $display("%0t: mom_x expected %h actual %h", $time, want.px, got.px);
        if (got.py !== want.py)
          $display("%0t: mom_y expected %h actual %h", $time, want.py, got.py);
        if (got.pz !== want.pz)
          $display("%0t: mom_z expected %h actual %h", $time, want.pz, got.pz);
        if (got.pass !== want.pass)
          $display("%0t: passed_through expected %b actual %b", $time,
                   want.pass, got.pass);
        if (got.inv !== want.inv)
          $display("%0t: invalid_beta expected %b actual %b", $time,
                   want.inv, got.inv);
        if (got.sat !== want.sat)
          $display("%0t: saturated expected %b actual %b", $time,
                   want.sat, got.sat);
        if (got !== want) errors++;
      end
    end
  end

  // Drives one item from the falling edge and holds it until it is taken.
  task automatic send_item(boost_item_t it, boosted_t want, bit idle_ok);
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    drv   <= it;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    boosted_q = {boosted_q, want};
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return SAT_MAX;
      3: return SAT_MIN;
      4: return '0;
      default: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
    endcase
  endfunction

  function automatic boost_item_t rand_item();
    boost_item_t it;
    it = {rand_word(), rand_word(), rand_word(), rand_word(),
          rand_word(), rand_word(), rand_word(), rand_word()};
    // Mostly physical frames: a small momentum under a larger energy.
    if ($urandom_range(0, 9) < 7) begin
      it.fx = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      it.fy = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      it.fz = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      it.ef = $urandom_range(0, 1) ? 32'($urandom_range(1 << 23, 32'h7fffffff))
                                   : -32'($urandom_range(1 << 23, 32'h7fffffff));
    end
    return it;
  endfunction

  table_row_t rows[$];
  table_row_t row;
  boost_item_t it;

  task automatic add_row(table_row_t r);
    rows = {rows, r};
  endtask

  initial begin
    // Zero frame momentum and zero frame energy pass the input through;
    // lightlike and superluminal frames give zeros with the invalid flag.
    add_row('{'{SAT_MAX, SAT_MIN, 32'h1, 32'hffffffff, 32'h10000, 0, 0, 0},
              1'b1, '{SAT_MAX, SAT_MIN, 32'h1, 32'hffffffff, 1, 0, 0}});
    add_row('{'{SAT_MIN, 32'h5, SAT_MAX, 0, 0, 32'h10000, 0, 0},
              1'b1, '{SAT_MIN, 32'h5, SAT_MAX, 0, 1, 0, 0}});
    add_row('{'{32'h10000, 0, 0, 0, 32'h10000, 32'h10000, 0, 0},
              1'b1, '{0, 0, 0, 0, 0, 1, 0}});
    add_row('{'{32'h10000, 0, 0, 0, 32'h10000, 0, 32'h20000, 0},
              1'b1, '{0, 0, 0, 0, 0, 1, 0}});
    add_row('{'{SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN, SAT_MAX, 0, 0},
              1'b0, '0});
    add_row('{'{32'h10000, 0, 0, 0, 32'h20000, 32'h10000, 0, 0}, 1'b0, '0});
    add_row('{'{32'h10000, 0, 0, 0, 32'hfffe0000, 0, 0, 32'h10000}, 1'b0, '0});
    add_row('{'{SAT_MAX, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MAX, 32'h1, 32'h1, 32'h1},
              1'b0, '0});
    add_row('{'{SAT_MIN, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MIN, 32'h7fff0000, 0, 0},
              1'b0, '0});
    add_row('{'{SAT_MAX, 0, 0, 0, 32'h1, 0, 0, 0}, 1'b1,
              '{SAT_MAX, 0, 0, 0, 1, 0, 0}});
    add_row('{'{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
              1'b1, '{0, 0, 0, 0, 0, 1, 0}});
    add_row('{'{SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 32'h7fffffff, 32'h7ffffff0,
                0, 0}, 1'b0, '0});

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      row = rows[i];
      send_item(row.item, row.known ? row.res : boost_into_frame(row.item), 1'b1);
    end
    for (int i = 0; i < 600; i++) begin
      it = rand_item();
      // The last stretch streams back to back with no idle cycles.
      send_item(it, boost_into_frame(it), i < 500);
    end
    start <= 1'b0;

    while (boosted_q.size() != 0) @(posedge clk_i);
    repeat (lbf_pkg::LATENCY + 10) @(posedge clk_i);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
